/* sv/sensor_packet_framer_macros.svh */
// assertion macros shared by the checker
`ifndef SENSOR_PACKET_FRAMER_MACROS_SVH
`define SENSOR_PACKET_FRAMER_MACROS_SVH

// same-cycle implication, off while reset is low
`define SPF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spf check failed");

// next-cycle implication, off while reset is low
`define SPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spf check failed");

`endif

/* sv/spf_pkg.sv */
// shared types and constants of the packet framer
package spf_pkg;

    localparam int unsigned JOBQ_DEPTH_DEF = 4;

    localparam logic [15:0] HEADER_RESET = 16'hEF01;
    localparam logic [31:0] ADDRESS_RESET = 32'hFFFF_FFFF;

    // register index as decoded from the address
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_ADDRESS = 1'b1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef logic [3:0] t_step;

    // byte positions within a frame
    localparam t_step STEP_HDR_HI  = 4'd0;
    localparam t_step STEP_HDR_LO  = 4'd1;
    localparam t_step STEP_ADDR_3  = 4'd2;
    localparam t_step STEP_ADDR_2  = 4'd3;
    localparam t_step STEP_ADDR_1  = 4'd4;
    localparam t_step STEP_ADDR_0  = 4'd5;
    localparam t_step STEP_ID      = 4'd6;
    localparam t_step STEP_LEN_HI  = 4'd7;
    localparam t_step STEP_BYTE8   = 4'd8;
    localparam t_step STEP_SUM_HI  = 4'd9;
    localparam t_step STEP_SUM_LO  = 4'd10;

    // one classified job between front and back
    typedef struct packed {
        logic        first;  // start job: emit the leading bytes
        logic        err;    // data with no open frame
        logic        chk;    // checksum follows
        logic [7:0]  id;
        logic [7:0]  len_hi;
        logic [7:0]  byte8;  // length low byte or payload byte
        logic [15:0] sum;
    } t_job;

endpackage

/* sv/spf_front.sv */
// front end: classifies input items and keeps the frame state
module spf_front
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_command,
    input  logic [7:0]  i_packet_id,
    input  logic [15:0] i_length_field,
    input  logic [7:0]  i_payload_byte,
    output t_job        o_job
);

    logic        r_open, n_open;
    logic [15:0] r_left, n_left;
    logic [15:0] r_sum, n_sum;
    t_job        job;

    always_comb begin
        n_open = r_open;
        n_left = r_left;
        n_sum  = r_sum;
        job    = '0;
        if (i_command == CMD_START) begin
            n_sum      = 16'(i_packet_id) + 16'(i_length_field[15:8])
                       + 16'(i_length_field[7:0]);
            n_left     = (i_length_field >= 16'd2) ? (i_length_field - 16'd2) : 16'd0;
            job.first  = 1'b1;
            job.id     = i_packet_id;
            job.len_hi = i_length_field[15:8];
            job.byte8  = i_length_field[7:0];
            job.chk    = (n_left == 16'd0);
            job.sum    = n_sum;
            n_open     = !job.chk;
        end else if (!r_open) begin
            job.err = 1'b1;
        end else begin
            n_sum     = r_sum + 16'(i_payload_byte);
            n_left    = r_left - 16'd1;
            job.byte8 = i_payload_byte;
            job.chk   = (n_left == 16'd0);
            job.sum   = n_sum;
            n_open    = !job.chk;
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
            r_sum  <= '0;
        end else if (i_accept) begin
            r_open <= n_open;
            r_left <= n_left;
            r_sum  <= n_sum;
        end
    end

endmodule

/* sv/spf_jobq.sv */
// short job queue between front and back
module spf_jobq
    import spf_pkg::*;
#(
    parameter int unsigned DEPTH = JOBQ_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_data,
    output logic o_full,
    input  logic i_rd,
    output t_job o_rd_data,
    output logic o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          wr_ok, rd_ok;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_ok     = i_wr && !o_full;
    assign rd_ok     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (rd_ok) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + CW'(1);
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* sv/spf_back.sv */
// back end: expands jobs into bytes and holds the output register
module spf_back
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_job_valid,
    output logic        o_job_pop,
    input  logic [15:0] i_header_word,
    input  logic [31:0] i_device_address,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [7:0]  o_tx_byte,
    output logic        o_run_end,
    output logic        o_frame_end,
    output logic        o_error
);

    logic       r_mid;
    t_step      r_step;
    logic       r_out_valid;
    logic [7:0] r_tx_byte;
    logic       r_run_end, r_frame_end, r_error;

    t_step      step;
    logic [7:0] byte_val;
    logic       last;
    logic       adv;

    // a fresh data or error job starts at the ninth byte position
    assign step = r_mid ? r_step : (i_job.first ? STEP_HDR_HI : STEP_BYTE8);

    always_comb begin
        case (step)
            STEP_HDR_HI: byte_val = i_header_word[15:8];
            STEP_HDR_LO: byte_val = i_header_word[7:0];
            STEP_ADDR_3: byte_val = i_device_address[31:24];
            STEP_ADDR_2: byte_val = i_device_address[23:16];
            STEP_ADDR_1: byte_val = i_device_address[15:8];
            STEP_ADDR_0: byte_val = i_device_address[7:0];
            STEP_ID:     byte_val = i_job.id;
            STEP_LEN_HI: byte_val = i_job.len_hi;
            STEP_BYTE8:  byte_val = i_job.byte8;
            STEP_SUM_HI: byte_val = i_job.sum[15:8];
            STEP_SUM_LO: byte_val = i_job.sum[7:0];
            default:     byte_val = 8'h00;
        endcase
    end

    assign last      = ((step == STEP_BYTE8) && !i_job.chk) || (step == STEP_SUM_LO);
    assign adv       = i_job_valid && (!r_out_valid || i_pop);
    assign o_job_pop = adv && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_step      <= STEP_HDR_HI;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_mid       <= !last;
                r_step      <= step + t_step'(1);
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tx_byte   <= byte_val;
            r_run_end   <= last;
            r_frame_end <= (step == STEP_SUM_LO);
            r_error     <= i_job.err;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_run_end   = r_run_end;
    assign o_frame_end = r_frame_end;
    assign o_error     = r_error;

endmodule

/* sv/sensor_packet_framer.sv */
// top level of the additive-checksum packet framer
//
//  channel   handshake            payload
//  ------    -------------------  ---------------------------------------------
//  input     push / full          i_command, i_packet_id, i_length_field,
//                                 i_payload_byte
//  result    empty / pop          o_tx_byte, o_run_end, o_frame_end, o_error
//  config    psel/penable/pwrite  paddr[2:0], pwdata / prdata (32 bits)
//
//  a start transaction yields 9 bytes, or 11 when the checksum follows at once;
//  a data transaction yields 1 byte, or 3 with the checksum; an error yields 1.
//  the back-end byte sequencer with its one output register paces the output.
//  the front takes a transaction every cycle while the job queue has room.
//  reset is synchronous, active low: frame closed, queue and output empty,
//  registers back to 0xEF01 / 0xFFFFFFFF. either side may stall at any time.
module sensor_packet_framer
    import spf_pkg::*;
#(
    parameter int unsigned JOBQ_DEPTH = JOBQ_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [7:0]  i_packet_id,
    input  logic [15:0] i_length_field,
    input  logic [7:0]  i_payload_byte,
    // result transactions
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_tx_byte,
    output logic        o_run_end,
    output logic        o_frame_end,
    output logic        o_error,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_header_word;
    logic [31:0] r_device_address;
    logic        cfg_wr;
    logic        in_accept;
    t_job        front_job;
    t_job        q_job;
    logic        q_empty;
    logic        q_pop;

    // register file: header at 0x0, address at 0x4
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_word    <= HEADER_RESET;
            r_device_address <= ADDRESS_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_HEADER:  r_header_word    <= pwdata[15:0];
                REG_ADDRESS: r_device_address <= pwdata;
                default:     r_device_address <= r_device_address;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HEADER:  prdata = {16'h0000, r_header_word};
            REG_ADDRESS: prdata = r_device_address;
            default:     prdata = '0;
        endcase
    end

    // the front updates frame state on every accepted transaction
    assign in_accept = push && !full;

    spf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_command      (i_command),
        .i_packet_id    (i_packet_id),
        .i_length_field (i_length_field),
        .i_payload_byte (i_payload_byte),
        .o_job          (front_job)
    );

    // jobs wait here while the back is busy with a long burst
    spf_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (in_accept),
        .i_wr_data (front_job),
        .o_full    (full),
        .i_rd      (q_pop),
        .o_rd_data (q_job),
        .o_empty   (q_empty)
    );

    spf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (q_job),
        .i_job_valid      (!q_empty),
        .o_job_pop        (q_pop),
        .i_header_word    (r_header_word),
        .i_device_address (r_device_address),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_tx_byte        (o_tx_byte),
        .o_run_end        (o_run_end),
        .o_frame_end      (o_frame_end),
        .o_error          (o_error)
    );

endmodule

/* sv/spf_checker.sv */
// port-level checks of the packet framer and their binding
`include "sensor_packet_framer_macros.svh"

module spf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_tx_byte,
    input logic       o_run_end,
    input logic       o_frame_end,
    input logic       o_error
);

    // the final checksum byte always closes the run of its transaction
    `SPF_ASSERT_SAME(a_frame_end_is_last, !empty && o_frame_end, o_run_end)

    // an error result stands alone, zero byte, no frame end
    `SPF_ASSERT_SAME(a_error_shape, !empty && o_error,
        o_run_end && !o_frame_end && (o_tx_byte == 8'h00))

    // a stalled result stays put
    `SPF_ASSERT_NEXT(a_stall_holds, !empty && !pop,
        !empty && $stable(o_tx_byte) && $stable(o_run_end))

endmodule

bind sensor_packet_framer spf_checker u_spf_checker (.*);

/* tb/sensor_packet_framer_tb.sv */
`timescale 1ns / 1ps
// self-checking packet framer testbench: reset, directed, checksum wrap, stall and random tests
module sensor_packet_framer_tb;
    import spf_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned MAX_PRINTS = 60;
    localparam logic [2:0] ADDR_HEADER = {REG_HEADER, 2'b00};
    localparam logic [2:0] ADDR_ADDRESS = {REG_ADDRESS, 2'b00};

    typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PATTERN} t_rx_mode;
    typedef enum logic {TX_STREAM, TX_BURSTY} t_tx_mode;

    // one transmitted byte with its flags
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       run_end;
        logic       frame_end;
        logic       error;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_command = CMD_START;
    logic [7:0]  i_packet_id = '0;
    logic [15:0] i_length_field = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_tx_byte;
    logic        o_run_end;
    logic        o_frame_end;
    logic        o_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sensor_packet_framer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_packet_id    (i_packet_id),
        .i_length_field (i_length_field),
        .i_payload_byte (i_payload_byte),
        .empty          (empty),
        .pop            (pop),
        .o_tx_byte      (o_tx_byte),
        .o_run_end      (o_run_end),
        .o_frame_end    (o_frame_end),
        .o_error        (o_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // framer copy: registers and frame state
    logic [15:0] mdl_header = HEADER_RESET;
    logic [31:0] mdl_address = ADDRESS_RESET;
    logic        mdl_open = 1'b0;
    logic [15:0] mdl_left = '0;
    logic [15:0] mdl_sum = '0;

    t_frame_byte tx_expect_q[$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_cycle = 0;
    t_rx_mode    rx_mode = RX_STEADY;
    t_tx_mode    tx_mode = TX_STREAM;
    logic        rx_hold = 1'b0;
    event        hold_start;

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH %s: got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    function automatic void queue_byte(logic [7:0] b, logic last, logic fend, logic err);
        t_frame_byte rec;
        rec.tx_byte = b;
        rec.run_end = last;
        rec.frame_end = fend;
        rec.error = err;
        tx_expect_q.push_back(rec);
    endfunction

    function automatic void queue_checksum();
        queue_byte(mdl_sum[15:8], 1'b0, 1'b0, 1'b0);
        queue_byte(mdl_sum[7:0], 1'b1, 1'b1, 1'b0);
        mdl_open = 1'b0;
        mdl_left = '0;
    endfunction

    // expected bytes of one accepted transaction
    function automatic void predict_frame_bytes(logic cmd, logic [7:0] id, logic [15:0] len,
                                                logic [7:0] data);
        logic chk;
        if (cmd == CMD_START) begin
            mdl_sum = 16'(id) + 16'(len[15:8]) + 16'(len[7:0]);
            mdl_left = (len >= 16'd2) ? len - 16'd2 : 16'd0;
            mdl_open = 1'b1;
            chk = (mdl_left == 16'd0);
            queue_byte(mdl_header[15:8], 1'b0, 1'b0, 1'b0);
            queue_byte(mdl_header[7:0], 1'b0, 1'b0, 1'b0);
            queue_byte(mdl_address[31:24], 1'b0, 1'b0, 1'b0);
            queue_byte(mdl_address[23:16], 1'b0, 1'b0, 1'b0);
            queue_byte(mdl_address[15:8], 1'b0, 1'b0, 1'b0);
            queue_byte(mdl_address[7:0], 1'b0, 1'b0, 1'b0);
            queue_byte(id, 1'b0, 1'b0, 1'b0);
            queue_byte(len[15:8], 1'b0, 1'b0, 1'b0);
            queue_byte(len[7:0], !chk, 1'b0, 1'b0);
            if (chk)
                queue_checksum();
        end else if (!mdl_open) begin
            // data with no open frame: error byte, state untouched
            queue_byte(8'h00, 1'b1, 1'b0, 1'b1);
        end else begin
            mdl_sum = mdl_sum + 16'(data);
            mdl_left = mdl_left - 16'd1;
            chk = (mdl_left == 16'd0);
            queue_byte(data, !chk, 1'b0, 1'b0);
            if (chk)
                queue_checksum();
        end
    endfunction

    // input monitor, result check and receiver stall pattern
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n) begin
            if (push && !full)
                predict_frame_bytes(i_command, i_packet_id, i_length_field, i_payload_byte);
            if (pop && !empty) begin
                if (tx_expect_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(o_tx_byte), 32'h0);
                end else begin
                    want = tx_expect_q.pop_front();
                    if (o_tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", 32'(o_tx_byte), 32'(want.tx_byte));
                    if (o_run_end !== want.run_end)
                        report_mismatch("run_end", 32'(o_run_end), 32'(want.run_end));
                    if (o_frame_end !== want.frame_end)
                        report_mismatch("frame_end", 32'(o_frame_end), 32'(want.frame_end));
                    if (o_error !== want.error)
                        report_mismatch("error", 32'(o_error), 32'(want.error));
                end
            end
        end
        rx_cycle++;
        case (rx_mode)
            RX_STEADY: begin
                pop <= !rx_hold;
            end
            RX_RANDOM: begin
                pop <= !rx_hold && ($urandom_range(0, 99) >= 35);
            end
            default: begin
                pop <= !rx_hold && (rx_cycle % 7 < 4) && !(rx_cycle[5] && rx_cycle[1]);
            end
        endcase
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_start);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // push stays high into the next transaction unless a gap is due
    task automatic send_item(logic cmd, logic [7:0] id, logic [15:0] len, logic [7:0] data);
        int unsigned gap;
        if (tx_mode == TX_BURSTY) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        push <= 1'b1;
        i_command <= cmd;
        i_packet_id <= id;
        i_length_field <= len;
        i_payload_byte <= data;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        burst_left = 0;
        while (tx_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one apb transfer; psel is left high so transfers can run back to back
    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic check_regs();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_HEADER, 32'h0, rd);
        if (rd[15:0] !== mdl_header)
            report_mismatch("header_word readback", rd, 32'(mdl_header));
        apb_access(1'b0, ADDR_ADDRESS, 32'h0, rd);
        if (rd !== mdl_address)
            report_mismatch("device_address readback", rd, mdl_address);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] hdr, logic [31:0] addr_word);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_HEADER, hdr, rd);
        mdl_header = hdr[15:0];
        apb_access(1'b1, ADDR_ADDRESS, addr_word, rd);
        mdl_address = addr_word;
        check_regs();
    endtask

    task automatic send_random_frame();
        int unsigned kind;
        int unsigned n;
        logic [15:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // stray data byte: an error unless an abandoned-length frame is still open
            send_item(CMD_DATA, 8'($urandom), 16'($urandom), 8'($urandom));
        end else if (kind < 20) begin
            // any length, cut short by the next start in most cases
            len = 16'($urandom);
            n = $urandom_range(0, 4);
            send_item(CMD_START, 8'($urandom), len, 8'($urandom));
            repeat (n) send_item(CMD_DATA, 8'($urandom), 16'($urandom), 8'($urandom));
        end else if (kind < 26) begin
            // length below two: checksum follows at once
            len = 16'($urandom_range(0, 1));
            send_item(CMD_START, 8'($urandom), len, 8'($urandom));
        end else begin
            n = $urandom_range(0, 12);
            send_item(CMD_START, 8'($urandom), 16'(n + 2), 8'($urandom));
            repeat (n) send_item(CMD_DATA, 8'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_reset_defaults();
        rx_mode = RX_STEADY;
        tx_mode = TX_STREAM;
        check_regs();
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'hFF);
        send_item(CMD_START, 8'h00, 16'd2, 8'h00);
        send_item(CMD_START, 8'hFF, 16'd0, 8'hFF);
        send_item(CMD_START, 8'h5A, 16'd1, 8'h00);
        send_item(CMD_DATA, 8'hFF, 16'hFFFF, 8'h00);
        drain_results();
    endtask

    task automatic test_directed();
        // header 0x0000 with junk in the unused upper bits
        set_config(32'hFFFF_0000, 32'h0000_0000);
        send_item(CMD_START, 8'h81, 16'd4, 8'h00);
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'hFF);
        // longest length, abandoned by a new start
        send_item(CMD_START, 8'h7E, 16'hFFFF, 8'h00);
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'hA5);
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'h5A);
        send_item(CMD_START, 8'h3C, 16'd3, 8'h00);
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'h96);
        send_item(CMD_DATA, 8'h11, 16'h1234, 8'h22);
        drain_results();
        set_config(32'h0000_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_START, 8'hFF, 16'h8000, 8'hFF);
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'h01);
        send_item(CMD_START, 8'h01, 16'h7FFF, 8'h00);
        send_item(CMD_START, 8'hC3, 16'd3, 8'h00);
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'h80);
        send_item(CMD_START, 8'h24, 16'd1, 8'h00);
        send_item(CMD_DATA, 8'h00, 16'h0000, 8'h7F);
        drain_results();
    endtask

    // id 0xFF, length 258 and 256 bytes of 0xFF carry the sum past 16 bits
    task automatic test_sum_wrap();
        set_config($urandom, $urandom);
        rx_mode = RX_RANDOM;
        tx_mode = TX_BURSTY;
        send_item(CMD_START, 8'hFF, 16'h0102, 8'h00);
        repeat (256) send_item(CMD_DATA, 8'($urandom), 16'($urandom), 8'hFF);
        drain_results();
    endtask

    task automatic test_backpressure();
        rx_mode = RX_STEADY;
        tx_mode = TX_STREAM;
        -> hold_start;
        repeat (8) send_random_frame();
        drain_results();
    endtask

    task automatic test_random();
        int unsigned phase;
        int unsigned phase_start;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    set_config($urandom, $urandom);
                    rx_mode = RX_RANDOM;
                    tx_mode = TX_BURSTY;
                end
                1: begin
                    set_config(32'h0000_0000, 32'hFFFF_FFFF);
                    rx_mode = RX_PATTERN;
                    tx_mode = TX_BURSTY;
                end
                2: begin
                    // no idling on either side
                    set_config(32'h0000_FFFF, 32'h0000_0000);
                    rx_mode = RX_STEADY;
                    tx_mode = TX_STREAM;
                end
                default: begin
                    set_config($urandom, $urandom);
                    rx_mode = RX_PATTERN;
                    tx_mode = TX_STREAM;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 25) send_random_frame();
            drain_results();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_sum_wrap();
        test_backpressure();
        test_random();
        if (tx_expect_q.size() != 0)
            report_mismatch("results never arrived", 32'(tx_expect_q.size()), 32'h0);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sensor_packet_framer.f */
+incdir+sv
sv/spf_pkg.sv
sv/spf_front.sv
sv/spf_jobq.sv
sv/spf_back.sv
sv/sensor_packet_framer.sv
sv/spf_checker.sv
tb/sensor_packet_framer_tb.sv
